@@ sv/array_linked_list_with_free_list_macros.svh @@
// ============================================================================
// Assertion macros for the linked-list node store
// Clocked on clk, quiet while rst_n is low.
// ============================================================================
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_MACROS_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ALFL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define ALFL_NEVER(label, cond, msg) \
    `ALFL_ASSERT(label, !(cond), msg)

`endif

@@ sv/alfl_pkg.sv @@
// ============================================================================
// alfl_pkg
// Shared types and constants of the linked-list node store.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package alfl_pkg;

    localparam int NODE_COUNT  = 16;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the transaction payloads
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    // Stored value width: values are kept in their low VALUE_WIDTH bits
    localparam int STORE_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

    // Node index and link pointer widths; a pointer can also hold null
    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PTR_W = $clog2(NODE_COUNT + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_ELEMENT   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_LINK,
        S_INS_TAIL,
        S_DEL_CMP,
        S_DEL_FREE,
        S_RD
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic signed [VAL_W-1:0] value_out;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

@@ sv/array_linked_list_with_free_list.sv @@
// ============================================================================
// array_linked_list_with_free_list
// Fixed node store holding a singly linked list and a free list threaded
// through one link memory.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   --------------------   ----------------------------------
//  command   start high, busy low   item   : op, value
//  result    result_valid strobe    result : status, value_out, last
//
//  Insert fills the free head node, advances the free list, terminates the
//  node (S_INS_LINK) and hangs it off the old tail (S_INS_TAIL) unless the
//  list was empty. Delete walks from the head in S_DEL_CMP to the match or
//  the list end and frees a match in S_DEL_FREE; read-out walks it in S_RD.
//  The walk is set by the registered read ports of both memories, one node
//  per cycle. Rejected commands (full, empty, undefined op) answer from idle.
//  Each result shows on result for one cycle, the cycle after it is formed.
//  Reset clears the list, the free list and the link valid bits at once; no
//  clearing pass is needed. The receiver cannot stall.
//
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_with_free_list (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire alfl_pkg::item_t item,
    output logic                 result_valid,
    output alfl_pkg::result_t    result
);

    import alfl_pkg::*;

    // ------------------------------------------------------------------------
    // Control and pointer registers
    // ------------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [STORE_W-1:0]   value_reg, value_next;
    logic [PTR_W-1:0]     node_reg, node_next;       // new node or walk cursor
    logic [PTR_W-1:0]     prev_reg, prev_next;       // node before the cursor
    logic [PTR_W-1:0]     list_head_reg, list_head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [PTR_W-1:0]     free_head_reg, free_head_next;
    logic [NODE_COUNT-1:0] link_valid_reg, link_valid_next;
    logic [IDX_W-1:0]     link_raddr_reg;
    result_t              result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    // ------------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------------
    logic                 val_we;
    logic [IDX_W-1:0]     val_waddr;
    logic [STORE_W-1:0]   val_wdata;
    logic [STORE_W-1:0]   val_rdata;
    logic                 link_we;
    logic [IDX_W-1:0]     link_waddr;
    logic [PTR_W-1:0]     link_wdata;
    logic [PTR_W-1:0]     link_rdata_raw;
    logic [PTR_W-1:0]     link_rd;
    logic [IDX_W-1:0]     rd_addr;

    logic                 accept;
    logic                 val_match;
    logic                 link_nil;
    logic                 head_nil;
    logic                 free_nil;
    logic [STORE_W-1:0]   item_val;

    alfl_ram #(
        .WIDTH (STORE_W),
        .DEPTH (NODE_COUNT)
    ) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    alfl_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NODE_COUNT)
    ) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rdata_raw)
    );

    // An entry never written since reset links to the next entry; the last
    // entry then comes out as null by itself.
    assign link_rd = link_valid_reg[link_raddr_reg] ? link_rdata_raw
                                                     : PTR_W'(link_raddr_reg) + 1'b1;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign item_val  = item.value[STORE_W-1:0];
    assign val_match = (val_rdata == value_reg);
    assign link_nil  = (link_rd >= NIL);
    assign head_nil  = (list_head_reg >= NIL);
    assign free_nil  = (free_head_reg >= NIL);

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.op)
                        OP_INSERT: if (!free_nil) state_next = S_INS_LINK;
                        OP_DELETE: if (!head_nil) state_next = S_DEL_CMP;
                        OP_READ:   if (!head_nil) state_next = S_RD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_LINK: state_next = head_nil ? S_IDLE : S_INS_TAIL;
            S_INS_TAIL: state_next = S_IDLE;
            S_DEL_CMP:
            begin
                if (val_match)
                begin
                    state_next = S_DEL_FREE;
                end
                else if (link_nil)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DEL_FREE: state_next = S_IDLE;
            S_RD:       if (link_nil) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Memory control, pointer updates and results
    // ------------------------------------------------------------------------
    always_comb
    begin
        value_next        = value_reg;
        node_next         = node_reg;
        prev_next         = prev_reg;
        list_head_next    = list_head_reg;
        tail_next         = tail_reg;
        free_head_next    = free_head_reg;
        val_we            = 1'b0;
        val_waddr         = node_reg[IDX_W-1:0];
        val_wdata         = value_reg;
        link_we           = 1'b0;
        link_waddr        = node_reg[IDX_W-1:0];
        link_wdata        = NIL;
        rd_addr           = node_reg[IDX_W-1:0];
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next                = item_val;
                    result_next.value_out     = VAL_W'(item_val);
                    result_next.last          = 1'b1;
                    result_next.status        = ST_EMPTY;
                    unique case (item.op) inside
                        OP_INSERT:
                        begin
                            if (free_nil)
                            begin
                                result_valid_next  = 1'b1;
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                // Fill the node now, fetch its link for the free head
                                val_we    = 1'b1;
                                val_waddr = free_head_reg[IDX_W-1:0];
                                val_wdata = item_val;
                                rd_addr   = free_head_reg[IDX_W-1:0];
                                node_next = free_head_reg;
                            end
                        end
                        OP_DELETE, OP_READ:
                        begin
                            if (head_nil)
                            begin
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                rd_addr   = list_head_reg[IDX_W-1:0];
                                node_next = list_head_reg;
                                prev_next = NIL;
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_INS_LINK:
            begin
                // Advance the free list and terminate the new node
                free_head_next = link_rd;
                link_we        = 1'b1;
                link_wdata     = NIL;
                if (head_nil)
                begin
                    list_head_next          = node_reg;
                    tail_next               = node_reg;
                    result_valid_next       = 1'b1;
                    result_next.status      = ST_INSERTED;
                    result_next.value_out   = VAL_W'(value_reg);
                    result_next.last        = 1'b1;
                end
            end

            S_INS_TAIL:
            begin
                // Hang the new node off the old tail, then advance the tail
                link_we               = 1'b1;
                link_waddr            = tail_reg[IDX_W-1:0];
                link_wdata            = node_reg;
                tail_next             = node_reg;
                result_valid_next     = 1'b1;
                result_next.status    = ST_INSERTED;
                result_next.value_out = VAL_W'(value_reg);
                result_next.last      = 1'b1;
            end

            S_DEL_CMP:
            begin
                if (val_match)
                begin
                    // Unlink the cursor node
                    if (prev_reg >= NIL)
                    begin
                        list_head_next = link_rd;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[IDX_W-1:0];
                        link_wdata = link_rd;
                    end
                    if (node_reg == tail_reg)
                    begin
                        tail_next = prev_reg;
                    end
                end
                else if (link_nil)
                begin
                    result_valid_next     = 1'b1;
                    result_next.status    = ST_NOT_FOUND;
                    result_next.value_out = VAL_W'(value_reg);
                    result_next.last      = 1'b1;
                end
                else
                begin
                    prev_next = node_reg;
                    node_next = link_rd;
                    rd_addr   = link_rd[IDX_W-1:0];
                end
            end

            S_DEL_FREE:
            begin
                // Push the freed node onto the free list
                link_we               = 1'b1;
                link_wdata            = free_head_reg;
                free_head_next        = node_reg;
                result_valid_next     = 1'b1;
                result_next.status    = ST_DELETED;
                result_next.value_out = VAL_W'(value_reg);
                result_next.last      = 1'b1;
            end

            S_RD:
            begin
                result_valid_next     = 1'b1;
                result_next.status    = ST_ELEMENT;
                result_next.value_out = VAL_W'(val_rdata);
                result_next.last      = link_nil;
                node_next             = link_rd;
                rd_addr               = link_rd[IDX_W-1:0];
            end

            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    // Mark link entries once written
    always_comb
    begin
        link_valid_next = link_valid_reg;
        if (link_we)
        begin
            link_valid_next[link_waddr] = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            list_head_reg    <= NIL;
            tail_reg         <= NIL;
            free_head_reg    <= '0;
            link_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            list_head_reg    <= list_head_next;
            tail_reg         <= tail_next;
            free_head_reg    <= free_head_next;
            link_valid_reg   <= link_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload and walk registers hold without reset
    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        node_reg       <= node_next;
        prev_reg       <= prev_next;
        link_raddr_reg <= rd_addr;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

@@ sv/alfl_ram.sv @@
// ============================================================================
// alfl_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module alfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/alfl_checker.sv @@
// ============================================================================
// alfl_checker
// Port-level checks of the linked-list node store, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "array_linked_list_with_free_list_macros.svh"

module alfl_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire alfl_pkg::item_t   item,
    input  wire logic              result_valid,
    input  wire alfl_pkg::result_t result
);

    import alfl_pkg::*;

    // Every accepted command either answers at once or goes busy
    `ALFL_ASSERT(a_accept_acts, start && !busy |=> busy || result_valid, "command dropped")

    // A list element only comes out of a walk
    `ALFL_ASSERT(a_elem_from_walk, result_valid && result.status == ST_ELEMENT |-> $past(busy), "element outside a walk")

    // Single-result transactions always carry last
    `ALFL_ASSERT(a_single_last, result_valid && result.status != ST_ELEMENT |-> result.last, "last missing")

    // The final result of a transaction leaves the block ready
    `ALFL_NEVER(a_last_idle, result_valid && result.last && busy, "busy after final result")

    // Status codes stay in range
    `ALFL_NEVER(a_status_range, result_valid && result.status > ST_ELEMENT, "bad status code")

endmodule

bind array_linked_list_with_free_list alfl_checker u_alfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Linked-list node store: command/result testbench
// Sends insert, delete, read-out and undefined commands. An in-bench model
// of the node store, free list and link array predicts every result, and a
// monitor checks each strobed result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import alfl_pkg::*;

    // The undefined op encoding: the block ignores it
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    // Longest healthy silence is a delete walking all nodes plus a long
    // sender gap; the limit is many times that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int POOL_SIZE      = 8;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    // Commands waiting to be driven, and results the model says must come
    item_t   pending_cmds[$];
    result_t awaited_results[$];

    // Model state: node values, next links, list and free-list heads
    logic [STORE_W-1:0] node_val  [NODE_COUNT];
    logic [PTR_W-1:0]   node_link [NODE_COUNT];
    logic [PTR_W-1:0]   list_head;
    logic [PTR_W-1:0]   free_head;

    // Values that inserts and deletes mostly draw from, so deletes hit
    logic [VAL_W-1:0]   value_pool [POOL_SIZE];

    int   idle_pct       = 17;
    int   cmds_queued    = 0;
    int   mismatch_count = 0;
    int   silent_cycles  = 0;
    logic cmd_taken      = 1'b0;

    array_linked_list_with_free_list uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the node store
    // ------------------------------------------------------------------------

    task automatic clear_store_model();
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            node_val[i]  = '0;
            node_link[i] = PTR_W'(i + 1);
        end
        // The last node's link is already NODE_COUNT, i.e. null
        list_head = NIL;
        free_head = '0;
    endtask

    task automatic await_result(input status_t st, input logic [VAL_W-1:0] v,
                                input logic fin);
        result_t r;
        r.status    = st;
        r.value_out = v;
        r.last      = fin;
        awaited_results.push_back(r);
    endtask

    // Apply one accepted command to the model and queue the results it causes
    task automatic apply_command(input item_t cmd);
        logic [PTR_W-1:0]   n;
        logic [PTR_W-1:0]   cur;
        logic [PTR_W-1:0]   prev;
        logic [PTR_W-1:0]   nxt;
        logic [VAL_W-1:0]   v;
        int                 steps;
        v = VAL_W'(cmd.value[STORE_W-1:0]);
        case (cmd.op)
            OP_INSERT:
            begin
                n = free_head;
                if (n >= NODE_COUNT)
                begin
                    await_result(ST_FULL, v, 1'b1);
                end
                else
                begin
                    // Take the free head, then hang it off the tail
                    free_head    = node_link[n];
                    node_val[n]  = v[STORE_W-1:0];
                    node_link[n] = NIL;
                    if (list_head >= NODE_COUNT)
                    begin
                        list_head = n;
                    end
                    else
                    begin
                        cur   = list_head;
                        steps = 0;
                        while (node_link[cur] < NODE_COUNT && steps < NODE_COUNT)
                        begin
                            cur = node_link[cur];
                            steps++;
                        end
                        node_link[cur] = n;
                    end
                    await_result(ST_INSERTED, v, 1'b1);
                end
            end
            OP_DELETE:
            begin
                cur   = list_head;
                prev  = NIL;
                steps = 0;
                if (cur >= NODE_COUNT)
                begin
                    await_result(ST_EMPTY, v, 1'b1);
                end
                else
                begin
                    while (cur < NODE_COUNT && steps < NODE_COUNT &&
                           node_val[cur] != v[STORE_W-1:0])
                    begin
                        prev = cur;
                        cur  = node_link[cur];
                        steps++;
                    end
                    if (cur >= NODE_COUNT || node_val[cur] != v[STORE_W-1:0])
                    begin
                        await_result(ST_NOT_FOUND, v, 1'b1);
                    end
                    else
                    begin
                        // Unlink the match, then push it onto the free list
                        if (prev >= NODE_COUNT)
                            list_head = node_link[cur];
                        else
                            node_link[prev] = node_link[cur];
                        node_link[cur] = free_head;
                        free_head      = cur;
                        await_result(ST_DELETED, v, 1'b1);
                    end
                end
            end
            OP_READ:
            begin
                if (list_head >= NODE_COUNT)
                begin
                    await_result(ST_EMPTY, v, 1'b1);
                end
                else
                begin
                    cur   = list_head;
                    steps = 0;
                    while (cur < NODE_COUNT && steps < NODE_COUNT)
                    begin
                        nxt = node_link[cur];
                        await_result(ST_ELEMENT, VAL_W'(node_val[cur]),
                                     (nxt >= NODE_COUNT) || (steps + 1 >= NODE_COUNT));
                        steps++;
                        cur = nxt;
                    end
                end
            end
            default:
            begin
                // Undefined op: ignored, answered as empty with the value echoed
                await_result(ST_EMPTY, v, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v);
        item_t c;
        c.op    = op;
        c.value = v;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return VAL_W'($urandom());
    endfunction

    // Random bursts: fill runs, drain runs, read-outs and some noise. Fill
    // runs long enough to reach a full store; drains mostly hit pool values.
    task automatic queue_random(input int count);
        int target;
        int kind;
        int len;
        target = cmds_queued + count;
        while (cmds_queued < target)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 18);
            value_pool[$urandom_range(0, POOL_SIZE - 1)] = VAL_W'($urandom());
            if (kind < 4)
            begin
                repeat (len) queue_cmd(OP_INSERT, pick_value());
            end
            else if (kind < 8)
            begin
                repeat (len) queue_cmd(OP_DELETE, pick_value());
            end
            else if (kind == 8)
            begin
                queue_cmd(OP_READ, VAL_W'($urandom()));
            end
            else
            begin
                // Noise: any op encoding, any value
                repeat ($urandom_range(1, 4))
                    queue_cmd(OP_W'($urandom_range(0, 3)), VAL_W'($urandom()));
            end
            if ($urandom_range(0, 1) == 1)
                queue_cmd(OP_READ, VAL_W'($urandom()));
        end
    endtask

    task automatic wait_for_sender();
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
    endtask

    initial
    begin
        logic [VAL_W-1:0] tail_val;
        clear_store_model();
        value_pool = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000};

        // Directed: empty-list cases and the undefined op first
        queue_cmd(OP_READ, 32'h0000_0001);
        queue_cmd(OP_DELETE, 32'h7FFF_FFFF);
        queue_cmd(OP_UNDEFINED, 32'hFFFF_FFFF);
        // Fill the store: corner values (zero twice), then random ones
        tail_val = '0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            tail_val = (i < POOL_SIZE) ? value_pool[i] : VAL_W'($urandom());
            queue_cmd(OP_INSERT, tail_val);
        end
        queue_cmd(OP_INSERT, 32'h1234_5678);   // store full
        queue_cmd(OP_READ, 32'h0);             // sixteen elements
        queue_cmd(OP_DELETE, 32'h0BAD_F00D);   // missing value
        queue_cmd(OP_DELETE, 32'h0000_0000);   // first of two matches, at the head
        queue_cmd(OP_DELETE, tail_val);        // tail node
        queue_cmd(OP_DELETE, 32'h0000_0000);   // the other match, mid-list
        queue_cmd(OP_READ, 32'h0);

        // Hold reset, then release it away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_random(100);
        wait_for_sender();
        idle_pct = 56;
        queue_random(100);
        wait_for_sender();
        idle_pct = 0;
        queue_random(100);
        wait_for_sender();

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS array_linked_list_with_free_list");
        else
            $display("FAIL array_linked_list_with_free_list");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: present a new transaction once the last one is taken
    // ------------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || cmd_taken)
        begin
            // Hold off at random; otherwise advance to the next command
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                item  <= pending_cmds.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on acceptance, check each strobed result
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            cmd_taken <= start && !busy;
            // Predict first, so a result on the same edge finds its expectation
            if (start && !busy)
                apply_command(item);

            if (result_valid)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with none awaited: status %0d value %h",
                                              result.status, result.value_out));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  result.status, want.status));
                    if (result.value_out !== want.value_out)
                        report_mismatch($sformatf("value_out %h, want %h",
                                                  result.value_out, want.value_out));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b",
                                                  result.last, want.last));
                end
            end

            // Watchdog: drop the run after a long stretch with no transaction
            if ((start && !busy) || result_valid)
                silent_cycles <= 0;
            else
                silent_cycles <= silent_cycles + 1;
            if (silent_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL array_linked_list_with_free_list");
                $finish;
            end
        end
    end

endmodule
